// ===== hdl/smf_pkg.sv =====
// Shared types and constants of the sliding median filter.
// Holds window geometry, payload structs, the control state type and the
// per-cycle operation that drives the chain of sorted cells. No dependencies.
`default_nettype none

package smf_pkg;

    // Window geometry; an even window still spans 2*HALF+1 samples
    localparam int WINDOW   = 17;
    localparam int HALF     = WINDOW / 2;
    localparam int SPAN     = 2 * HALF + 1;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = $clog2(SPAN + 1);
    localparam int IDX_W    = $clog2(SPAN);
    localparam int CTR_W    = $clog2(HALF + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    stream_last;
    } in_item_t;

    typedef struct packed {
        sample_t median;
        logic    run_last;
        logic    stream_end;
    } out_item_t;

    // Control state: normal streaming, or draining owed results after the last sample
    typedef enum logic [0:0] {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } state_t;

    // What the chain does in each cycle
    typedef struct packed {
        logic    shift_en;  // shift the history taps by one
        logic    ins_en;    // insert ins_val into the sorted row
        logic    del_en;    // remove one copy of del_val from the sorted row
        sample_t ins_val;
        sample_t del_val;
    } chain_op_t;

endpackage : smf_pkg

`default_nettype wire

// ===== hdl/smf_if.sv =====
// Valid/ready channel interfaces of the sliding median filter.
// Depends on smf_pkg for the input and result payload structs.
`default_nettype none

interface smf_in_if;
    logic              valid;
    logic              ready;
    smf_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface : smf_in_if

interface smf_out_if;
    logic               valid;
    logic               ready;
    smf_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface : smf_out_if

`default_nettype wire

// ===== hdl/smf_cell.sv =====
// One slot of the sorted row plus one history tap.
// Depends on smf_pkg; neighbors exchange their values every cycle.
`default_nettype none

module smf_cell (
    input  wire logic               clk,
    input  wire smf_pkg::chain_op_t op,
    input  wire logic               valid_mid,  // slot holds a live entry after the delete
    input  wire logic               prev_lt,    // left neighbor's post-delete entry < ins_val
    input  wire smf_pkg::sample_t   prev_mid,   // left neighbor's post-delete entry
    input  wire smf_pkg::sample_t   next_sort,  // right neighbor's stored entry
    input  wire smf_pkg::sample_t   hist_in,    // history tap to the left
    output smf_pkg::sample_t        sort_val,
    output smf_pkg::sample_t        mid_val,
    output logic                    mid_lt,
    output smf_pkg::sample_t        hist_val
);

    smf_pkg::sample_t sort_reg;
    smf_pkg::sample_t sort_next;
    smf_pkg::sample_t hist_reg;
    smf_pkg::sample_t del_v;
    smf_pkg::sample_t ins_v;

    assign del_v = op.del_val;
    assign ins_v = op.ins_val;

    // Drop: slots at or above the evicted value take their right neighbor
    assign mid_val = (op.del_en && !(sort_reg < del_v)) ? next_sort : sort_reg;

    // Insert: smaller entries hold, the first slot not smaller takes the new value,
    // the rest move one slot to the right
    assign mid_lt = valid_mid && (mid_val < ins_v);

    always_comb
    begin
        if (!op.ins_en || mid_lt)
        begin
            sort_next = mid_val;
        end
        else if (prev_lt)
        begin
            sort_next = ins_v;
        end
        else
        begin
            sort_next = prev_mid;
        end
    end

    // Advance the sorted slot every cycle
    always_ff @(posedge clk)
    begin
        sort_reg <= sort_next;
    end

    // Shift the history tap on each accepted sample
    always_ff @(posedge clk)
    begin
        if (op.shift_en)
        begin
            hist_reg <= hist_in;
        end
    end

    assign sort_val = sort_reg;
    assign hist_val = hist_reg;

endmodule : smf_cell

`default_nettype wire

// ===== hdl/smf_chain.sv =====
// Row of smf_cell instances: sorted window contents and the sample history.
// Depends on smf_pkg and smf_cell; selects the median and the evicted sample.
`default_nettype none

module smf_chain (
    input  wire logic                        clk,
    input  wire smf_pkg::chain_op_t          op,
    input  wire logic [smf_pkg::CNT_W-1:0]   cnt,        // live entries before this op
    input  wire logic [smf_pkg::IDX_W-1:0]   med_idx,
    input  wire logic [smf_pkg::IDX_W-1:0]   evict_idx,
    output smf_pkg::sample_t                 med_val,
    output smf_pkg::sample_t                 evict_val
);

    localparam int SPAN = smf_pkg::SPAN;
    localparam int CW   = smf_pkg::CNT_W;

    smf_pkg::sample_t sort_w [SPAN];
    smf_pkg::sample_t mid_w  [SPAN];
    smf_pkg::sample_t hist_w [SPAN];
    logic             lt_w   [SPAN];
    logic [CW-1:0]    cnt_mid;

    // Live entries left after the delete half of the op
    assign cnt_mid = cnt - CW'(op.del_en);

    for (genvar g = 0; g < SPAN; g++)
    begin : g_cell
        logic             valid_mid;
        logic             prev_lt;
        smf_pkg::sample_t prev_mid;
        smf_pkg::sample_t next_sort;
        smf_pkg::sample_t hist_in;

        assign valid_mid = (CW'(g) < cnt_mid);

        if (g == 0)
        begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_mid = mid_w[g];
            assign hist_in  = op.ins_val;
        end
        else
        begin : g_inner
            assign prev_lt  = lt_w[g-1];
            assign prev_mid = mid_w[g-1];
            assign hist_in  = hist_w[g-1];
        end

        if (g == SPAN - 1)
        begin : g_last
            assign next_sort = sort_w[g];
        end
        else
        begin : g_body
            assign next_sort = sort_w[g+1];
        end

        smf_cell u_cell (
            .clk       (clk),
            .op        (op),
            .valid_mid (valid_mid),
            .prev_lt   (prev_lt),
            .prev_mid  (prev_mid),
            .next_sort (next_sort),
            .hist_in   (hist_in),
            .sort_val  (sort_w[g]),
            .mid_val   (mid_w[g]),
            .mid_lt    (lt_w[g]),
            .hist_val  (hist_w[g])
        );
    end

    // Pick the middle of the sorted row and the oldest live history entry
    assign med_val   = sort_w[med_idx];
    assign evict_val = hist_w[evict_idx];

endmodule : smf_chain

`default_nettype wire

// ===== hdl/sliding_median_filter_1d.sv =====
// Running median filter over a stream of signed 16-bit samples.
// Takes a stream on samples (payload: sample, stream_last) and gives one
// median per sample on results (payload: median, run_last, stream_end).
// The window is centered and WINDOW wide, clipped at both stream ends; the
// upper median of the clipped set is given. Result i leaves once sample
// i+HALF has been taken; the first HALF samples of a stream give nothing.
// A sorted row of cells takes an insert and an evict in the same cycle, so the
// block takes one sample per clock while results are drained; a result is
// read from the updated row and then loaded into the result register. A sample
// marked stream_last is followed by HALF+1 results at most, one per clock
// while results are taken, with samples.ready low; the final one carries run_last and
// stream_end, and the block then starts a new stream.
// A stall on results holds the result register and, once a result is pending, the
// sample input; no transaction is lost. Reset empties the window and the
// result register; the row and history need no clearing.
// Depends on smf_pkg, smf_if, smf_cell and smf_chain.
`default_nettype none

module sliding_median_filter_1d (
    input  wire logic  clk,
    input  wire logic  rst_n,
    smf_in_if.sink     samples,
    smf_out_if.source  results
);

    localparam int SPAN = smf_pkg::SPAN;
    localparam int HALF = smf_pkg::HALF;
    localparam int CW   = smf_pkg::CNT_W;
    localparam int IW   = smf_pkg::IDX_W;
    localparam int TW   = smf_pkg::CTR_W;

    smf_pkg::state_t    state_reg;
    smf_pkg::state_t    state_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [TW-1:0]      ctr_reg;
    logic [TW-1:0]      ctr_next;
    logic               pend_reg;
    logic               pend_next;
    logic               out_valid_reg;
    smf_pkg::out_item_t out_item_reg;

    logic               run_mode;
    logic               flush_mode;
    logic               med_move;
    logic               in_ready;
    logic               accept;
    logic               is_last;
    logic               flush_step;
    logic               flush_done;
    logic               shrink;
    logic               full;
    logic [TW-1:0]      ctr_dec;
    logic [CW-1:0]      cnt_ins;
    logic [CW-1:0]      cnt_dec;
    logic [IW-1:0]      med_idx;
    logic [IW-1:0]      evict_idx;
    smf_pkg::sample_t   med_val;
    smf_pkg::sample_t   evict_val;
    smf_pkg::chain_op_t op;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smf_pkg::ST_RUN:
            begin
                if (accept && is_last)
                begin
                    state_next = smf_pkg::ST_FLUSH;
                end
            end
            smf_pkg::ST_FLUSH:
            begin
                if (flush_done)
                begin
                    state_next = smf_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = smf_pkg::ST_RUN;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        run_mode   = 1'b0;
        flush_mode = 1'b0;
        unique case (state_reg)
            smf_pkg::ST_RUN:   run_mode   = 1'b1;
            smf_pkg::ST_FLUSH: flush_mode = 1'b1;
            default:           run_mode   = 1'b0;
        endcase
    end

    // Handshake and step control
    assign med_move   = pend_reg && (!out_valid_reg || results.ready);
    assign in_ready   = run_mode && (!pend_reg || med_move);
    assign accept     = samples.valid && in_ready;
    assign is_last    = samples.payload.stream_last;
    assign flush_step = flush_mode && med_move && (ctr_reg != '0);
    assign flush_done = flush_mode && med_move && (ctr_reg == '0);
    assign ctr_dec    = ctr_reg - TW'(1);
    assign full       = (cnt_reg == CW'(SPAN));
    assign cnt_ins    = full ? cnt_reg : cnt_reg + CW'(1);
    assign cnt_dec    = cnt_reg - CW'(1);

    // Shrink the clipped window when the next center no longer reaches the oldest entry
    assign shrink = flush_step && ((CW'(ctr_dec) + CW'(HALF)) < cnt_dec);

    assign med_idx   = IW'(cnt_reg >> 1);
    assign evict_idx = (cnt_reg == '0) ? '0 : IW'(cnt_dec);

    // Chain operation for this cycle
    always_comb
    begin
        op.shift_en = accept;
        op.ins_en   = accept;
        op.del_en   = (accept && full) || shrink;
        op.ins_val  = samples.payload.sample;
        op.del_val  = evict_val;
    end

    smf_chain u_chain (
        .clk       (clk),
        .op        (op),
        .cnt       (cnt_reg),
        .med_idx   (med_idx),
        .evict_idx (evict_idx),
        .med_val   (med_val),
        .evict_val (evict_val)
    );

    // Next window count, owed-result counter and pending flag
    always_comb
    begin
        cnt_next  = cnt_reg;
        ctr_next  = ctr_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            cnt_next  = cnt_ins;
            pend_next = is_last || (cnt_ins > CW'(HALF));
            if (is_last)
            begin
                ctr_next = (cnt_reg < CW'(HALF)) ? TW'(cnt_ins - CW'(1)) : TW'(HALF);
                if (full)
                begin
                    ctr_next = TW'(HALF);
                end
            end
        end
        else if (flush_done)
        begin
            cnt_next  = '0;
            pend_next = 1'b0;
        end
        else if (flush_step)
        begin
            ctr_next = ctr_dec;
            if (shrink)
            begin
                cnt_next = cnt_dec;
            end
        end
        else if (med_move)
        begin
            pend_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smf_pkg::ST_RUN;
            cnt_reg   <= '0;
            ctr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ctr_reg   <= ctr_next;
            pend_reg  <= pend_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (med_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (med_move)
        begin
            out_item_reg.median     <= med_val;
            out_item_reg.run_last   <= !flush_mode || (ctr_reg == '0);
            out_item_reg.stream_end <= flush_mode && (ctr_reg == '0);
        end
    end

    assign samples.ready   = in_ready;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

endmodule : sliding_median_filter_1d

`default_nettype wire
